// ===== rtl/cesd_pkg.sv =====
// Shared types and constants for the C escape sequence decoder.
package cesd_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // Up to three results per source byte, always in slot order:
  // flushed escape byte, current byte, end-of-string result.
  typedef struct packed {
    logic       pend_v;
    logic [7:0] pend_byte;
    logic       cur_v;
    logic [7:0] cur_byte;
    logic       end_v;
    logic       end_err;
  } rec_t;

  typedef struct packed {
    logic push;
  } qin_t;

  typedef struct packed {
    logic pop;
  } qout_t;

endpackage

// ===== rtl/cesd_front.sv =====
// Front end: escape state machine, turns each source byte into one result record.
module cesd_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             acc_en,
  input  logic [7:0]       in_byte,
  input  logic             in_is_last,
  output cesd_pkg::rec_t   rec,
  output logic             rec_v
);
  import cesd_pkg::*;

  typedef enum logic [5:0] {
    M_TEXT = 6'b000001,
    M_ESC  = 6'b000010,
    M_OCT  = 6'b000100,
    M_HEX0 = 6'b001000,
    M_HEX  = 6'b010000,
    M_DROP = 6'b100000
  } mode_t;

  localparam logic [7:0] CH_BSL  = 8'h5C;

  mode_t      mode_r, mode_nxt;
  logic [8:0] acc_r, acc_nxt;
  logic       hov_r, hov_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  logic       is_oct, is_hex, do_text, ended;
  logic [3:0] hval;
  logic [7:0] hsum;
  logic [1:0] cnt_inc;

  // Simple escape letter to byte; bit 8 flags a match.
  function automatic logic [8:0] simple_esc(input logic [7:0] b);
    logic [8:0] r;
    case (b)
      8'h61:   r = {1'b1, 8'd7};
      8'h62:   r = {1'b1, 8'd8};
      8'h66:   r = {1'b1, 8'd12};
      8'h6E:   r = {1'b1, 8'd10};
      8'h72:   r = {1'b1, 8'd13};
      8'h74:   r = {1'b1, 8'd9};
      8'h76:   r = {1'b1, 8'd11};
      8'h5C:   r = {1'b1, 8'd92};
      8'h3F:   r = {1'b1, 8'd63};
      8'h27:   r = {1'b1, 8'd39};
      8'h22:   r = {1'b1, 8'd34};
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  always_comb begin
    logic [8:0] se;
    is_oct  = in_byte inside {[8'h30:8'h37]};
    is_hex  = in_byte inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
    hsum    = (in_byte > 8'h39) ? in_byte + 8'd9 : in_byte;
    hval    = hsum[3:0];
    cnt_inc = cnt_r + 2'd1;
    se      = simple_esc(in_byte);

    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    hov_nxt  = hov_r;
    cnt_nxt  = cnt_r;
    rec      = '0;
    do_text  = 1'b0;
    ended    = 1'b0;

    case (mode_r)
      M_TEXT: do_text = 1'b1;
      M_ESC: begin
        if (in_byte == 8'd0) begin
          mode_nxt = M_DROP;
          ended    = 1'b1;
        end else if (se[8]) begin
          mode_nxt     = M_TEXT;
          rec.cur_v    = 1'b1;
          rec.cur_byte = se[7:0];
        end else if (in_byte == 8'h78 || in_byte == 8'h58) begin
          mode_nxt = M_HEX0;
        end else if (is_oct) begin
          acc_nxt  = {6'd0, in_byte[2:0]};
          cnt_nxt  = 2'd1;
          mode_nxt = M_OCT;
        end else begin
          mode_nxt = M_DROP;
        end
      end
      M_OCT: begin
        if (is_oct) begin
          acc_nxt = {acc_r[5:0], in_byte[2:0]};
          cnt_nxt = cnt_inc;
          if (cnt_inc == 2'd3) begin
            rec.pend_v    = 1'b1;
            rec.pend_byte = {acc_r[4:0], in_byte[2:0]};
            mode_nxt      = M_TEXT;
          end
        end else begin
          rec.pend_v    = 1'b1;
          rec.pend_byte = acc_r[7:0];
          mode_nxt      = M_TEXT;
          do_text       = 1'b1;
        end
      end
      M_HEX0: begin
        if (is_hex) begin
          acc_nxt  = {5'd0, hval};
          hov_nxt  = 1'b0;
          mode_nxt = M_HEX;
        end else begin
          mode_nxt = M_DROP;
          ended    = (in_byte == 8'd0);
        end
      end
      M_HEX: begin
        if (is_hex) begin
          if (acc_r[8:4] != 5'd0) hov_nxt = 1'b1;
          acc_nxt = {acc_r[4:0], hval};
        end else if (hov_r) begin
          mode_nxt = M_DROP;
          ended    = (in_byte == 8'd0);
        end else begin
          rec.pend_v    = 1'b1;
          rec.pend_byte = acc_r[7:0];
          mode_nxt      = M_TEXT;
          do_text       = 1'b1;
        end
      end
      default: ended = (in_byte == 8'd0);
    endcase

    if (do_text) begin
      if (in_byte == 8'd0) begin
        ended = 1'b1;
      end else if (in_byte == CH_BSL) begin
        mode_nxt = M_ESC;
      end else begin
        rec.cur_v    = 1'b1;
        rec.cur_byte = in_byte;
      end
    end

    if (ended || in_is_last) begin
      // Flush an open numeric escape, then close the string.
      if (mode_nxt == M_OCT || (mode_nxt == M_HEX && !hov_nxt)) begin
        rec.pend_v    = 1'b1;
        rec.pend_byte = acc_nxt[7:0];
        mode_nxt      = M_TEXT;
      end else if (mode_nxt == M_HEX || mode_nxt == M_ESC || mode_nxt == M_HEX0) begin
        mode_nxt = M_DROP;
      end
      rec.end_v   = 1'b1;
      rec.end_err = (mode_nxt != M_TEXT);
      mode_nxt    = M_TEXT;
      acc_nxt     = 9'd0;
      hov_nxt     = 1'b0;
      cnt_nxt     = 2'd0;
    end

    rec_v = rec.pend_v | rec.cur_v | rec.end_v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_TEXT;
      acc_r  <= 9'd0;
      hov_r  <= 1'b0;
      cnt_r  <= 2'd0;
    end else if (acc_en) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      hov_r  <= hov_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/cesd_queue.sv =====
// Short record queue between the front end and the output serializer.
module cesd_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  cesd_pkg::qin_t  qin,
  input  cesd_pkg::rec_t  wr_rec,
  input  cesd_pkg::qout_t qout_ctl,
  output logic            full,
  output logic            head_v,
  output cesd_pkg::rec_t  head_rec
);
  import cesd_pkg::*;

  rec_t         ent_r [QDEPTH];
  logic [QAW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;
  logic         do_push, do_pop;

  assign full     = (cnt_r == (QAW+1)'(QDEPTH));
  assign head_v   = (cnt_r != '0);
  assign head_rec = ent_r[rp_r];

  always_comb begin
    do_push = qin.push && !full;
    do_pop  = qout_ctl.pop && head_v;
    wp_nxt  = do_push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (QAW+1)'(do_push) - (QAW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) ent_r[wp_r] <= wr_rec;
  end

endmodule

// ===== rtl/cesd_back.sv =====
// Back end: unpacks queued records into single results behind an output register.
module cesd_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            head_v,
  input  cesd_pkg::rec_t  head_rec,
  output cesd_pkg::qout_t qctl,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_byte,
  output logic [1:0]      out_kind,
  output logic            out_end_of_run
);
  import cesd_pkg::*;

  logic [2:0] taken_r, taken_nxt;
  logic [2:0] avail, first, rest;
  logic       load;
  logic       ov_r, ov_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic       eor_r, eor_nxt;

  always_comb begin
    avail = {head_rec.end_v, head_rec.cur_v, head_rec.pend_v} & ~taken_r;
    first = avail & (~avail + 3'd1);
    rest  = avail & ~first;
    load  = head_v && (!ov_r || out_ready);

    taken_nxt = taken_r;
    ov_nxt    = ov_r;
    byte_nxt  = byte_r;
    kind_nxt  = kind_r;
    eor_nxt   = eor_r;

    if (load) begin
      ov_nxt    = 1'b1;
      eor_nxt   = (rest == 3'd0);
      taken_nxt = (rest == 3'd0) ? 3'd0 : (taken_r | first);
      if (first[0]) begin
        byte_nxt = head_rec.pend_byte;
        kind_nxt = KIND_BYTE;
      end else if (first[1]) begin
        byte_nxt = head_rec.cur_byte;
        kind_nxt = KIND_BYTE;
      end else begin
        byte_nxt = 8'd0;
        kind_nxt = head_rec.end_err ? KIND_ERR : KIND_DONE;
      end
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end

    qctl.pop = load && (rest == 3'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taken_r <= 3'd0;
      ov_r    <= 1'b0;
    end else begin
      taken_r <= taken_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    kind_r <= kind_nxt;
    eor_r  <= eor_nxt;
  end

  assign out_valid      = ov_r;
  assign out_byte       = byte_r;
  assign out_kind       = kind_r;
  assign out_end_of_run = eor_r;

endmodule

// ===== rtl/c_escape_sequence_decoder_top.sv =====
// Top level of the C escape sequence decoder: front end, record queue, serializer.
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------------------
//   input    | in_valid / in_ready  | in_byte[7:0], in_is_last
//   result   | out_valid / out_ready| out_byte[7:0], out_kind[1:0], out_end_of_run
//
// One source byte is taken per cycle while the 4-entry record queue has room.
// Each byte yields 0 to 3 results; bytes with none are not queued, and a queued
// record stays at the queue head until the serializer has loaded all its results.
// The first result of a byte passes through the record queue and the output register.
// Synchronous active-low reset returns the decoder to plain text, empties the
// queue and drops any result held in the output register.
// A stalled output fills the queue; in_ready then drops until a record drains.
module c_escape_sequence_decoder_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_is_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [1:0] out_kind,
  output logic       out_end_of_run
);
  import cesd_pkg::*;

  rec_t  rec, head_rec;
  logic  rec_v, full, head_v, xfer;
  qin_t  qin;
  qout_t qctl;

  // Take a byte whenever the queue can hold its record.
  assign in_ready = !full;
  assign xfer     = in_valid && in_ready;

  // Push only bytes that produce results; a lone backslash or digit just
  // advances the escape state.
  assign qin.push = xfer && rec_v;

  cesd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc_en     (xfer),
    .in_byte    (in_byte),
    .in_is_last (in_is_last),
    .rec        (rec),
    .rec_v      (rec_v)
  );

  cesd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .qin      (qin),
    .wr_rec   (rec),
    .qout_ctl (qctl),
    .full     (full),
    .head_v   (head_v),
    .head_rec (head_rec)
  );

  cesd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_v         (head_v),
    .head_rec       (head_rec),
    .qctl           (qctl),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_kind       (out_kind),
    .out_end_of_run (out_end_of_run)
  );

endmodule

// ===== dv/tb_c_escape_sequence_decoder_top.sv =====
// Self-checking testbench for the C escape sequence decoder: directed and random strings.
module tb_c_escape_sequence_decoder_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cesd_pkg::*;

  // Decoder modes of the predictor.
  typedef enum logic [2:0] {
    MODE_TEXT, MODE_ESC, MODE_OCT, MODE_HEX0, MODE_HEX, MODE_DROP
  } mode_e;

  // How a string is closed: mark on its final byte, a zero byte, or a zero byte with the mark.
  typedef enum int { END_LAST, END_ZERO, END_ZERO_LAST } ending_e;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic       eor;
  } decoded_t;

  typedef logic [7:0] byte_q_t[$];

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_BSL = 8'h5c;
  localparam logic [7:0] CH_0   = "0";
  localparam logic [7:0] CH_7   = "7";
  localparam logic [7:0] CH_9   = "9";

  // Predicts the decoded stream from accepted source bytes and checks the results in order.
  class unescape_checker;
    mode_e       mode;
    logic [8:0]  accum;
    logic        hex_over;
    logic [1:0]  oct_digits;
    decoded_t    step_out[$];
    decoded_t    due[$];
    int unsigned mismatches;

    function new();
      clear_escape();
      mismatches = 0;
    endfunction

    function void clear_escape();
      mode       = MODE_TEXT;
      accum      = '0;
      hex_over   = 1'b0;
      oct_digits = '0;
    endfunction

    function bit is_oct(logic [7:0] c);
      return c >= CH_0 && c <= CH_7;
    endfunction

    function bit is_hex(logic [7:0] c);
      return (c >= CH_0 && c <= CH_9) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function logic [3:0] hex_digit(logic [7:0] c);
      logic [7:0] x;
      x = c;
      if (x > CH_9) x = x + 8'd9;
      return x[3:0];
    endfunction

    function void put(logic [7:0] d, logic [1:0] k);
      step_out.insert(step_out.size(), '{data: d, kind: k, eor: 1'b0});
    endfunction

    // Plain text byte; returns 1 when it closes the string.
    function bit plain_byte(logic [7:0] c);
      if (c == CH_NUL) return 1'b1;
      if (c == CH_BSL) mode = MODE_ESC;
      else put(c, KIND_BYTE);
      return 1'b0;
    endfunction

    function void open_escape(logic [7:0] c);
      mode = MODE_TEXT;
      case (c)
        "a":    put(8'd7, KIND_BYTE);
        "b":    put(8'd8, KIND_BYTE);
        "f":    put(8'd12, KIND_BYTE);
        "n":    put(8'd10, KIND_BYTE);
        "r":    put(8'd13, KIND_BYTE);
        "t":    put(8'd9, KIND_BYTE);
        "v":    put(8'd11, KIND_BYTE);
        CH_BSL: put(CH_BSL, KIND_BYTE);
        "?":    put("?", KIND_BYTE);
        "'":    put("'", KIND_BYTE);
        "\"":   put("\"", KIND_BYTE);
        "x", "X": mode = MODE_HEX0;
        default: begin
          if (is_oct(c)) begin
            accum      = 9'(c - CH_0);
            oct_digits = 2'd1;
            mode       = MODE_OCT;
          end else begin
            mode = MODE_DROP;
          end
        end
      endcase
    endfunction

    function void note_source_byte(logic [7:0] c, logic last);
      bit          ended;
      logic [12:0] v;
      step_out.delete();
      ended = 1'b0;
      case (mode)
        MODE_TEXT: ended = plain_byte(c);
        MODE_ESC: begin
          if (c == CH_NUL) begin
            mode  = MODE_DROP;
            ended = 1'b1;
          end else begin
            open_escape(c);
          end
        end
        MODE_OCT: begin
          if (is_oct(c)) begin
            accum      = 9'((accum << 3) + (c - CH_0));
            oct_digits = oct_digits + 2'd1;
            if (oct_digits == 2'd3) begin
              put(accum[7:0], KIND_BYTE);
              mode = MODE_TEXT;
            end
          end else begin
            put(accum[7:0], KIND_BYTE);
            mode  = MODE_TEXT;
            ended = plain_byte(c);
          end
        end
        MODE_HEX0: begin
          if (is_hex(c)) begin
            accum    = 9'(hex_digit(c));
            hex_over = 1'b0;
            mode     = MODE_HEX;
          end else begin
            mode  = MODE_DROP;
            ended = (c == CH_NUL);
          end
        end
        MODE_HEX: begin
          if (is_hex(c)) begin
            v = (13'(accum) << 4) + 13'(hex_digit(c));
            if (v > 13'h0ff) hex_over = 1'b1;
            accum = v[8:0];
          end else if (hex_over) begin
            mode  = MODE_DROP;
            ended = (c == CH_NUL);
          end else begin
            put(accum[7:0], KIND_BYTE);
            mode  = MODE_TEXT;
            ended = plain_byte(c);
          end
        end
        default: ended = (c == CH_NUL);
      endcase

      // Close the string: flush a pending escape byte, then the done or error result.
      if (ended || last) begin
        if (mode == MODE_OCT) begin
          put(accum[7:0], KIND_BYTE);
          mode = MODE_TEXT;
        end else if (mode == MODE_HEX) begin
          if (hex_over) begin
            mode = MODE_DROP;
          end else begin
            put(accum[7:0], KIND_BYTE);
            mode = MODE_TEXT;
          end
        end else if (mode == MODE_ESC || mode == MODE_HEX0) begin
          mode = MODE_DROP;
        end
        put(8'h00, (mode == MODE_TEXT) ? KIND_DONE : KIND_ERR);
        clear_escape();
      end

      if (step_out.size() != 0) step_out[step_out.size() - 1].eor = 1'b1;
      foreach (step_out[i]) due.insert(due.size(), step_out[i]);
    endfunction

    function void check_decoded(logic [7:0] b, logic [1:0] k, logic e);
      decoded_t want;
      if (due.size() == 0) begin
        $display("%0t: unexpected result: byte %02h kind %0d end_of_run %0b", $time, b, k, e);
        mismatches++;
        return;
      end
      want = due.pop_front();
      if (want.data !== b) begin
        $display("%0t: out_byte expected %02h actual %02h", $time, want.data, b);
        mismatches++;
      end
      if (want.kind !== k) begin
        $display("%0t: out_kind expected %0d actual %0d", $time, want.kind, k);
        mismatches++;
      end
      if (want.eor !== e) begin
        $display("%0t: out_end_of_run expected %0b actual %0b", $time, want.eor, e);
        mismatches++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n      = 1'b0;
  logic       in_valid   = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte    = 8'h00;
  logic       in_is_last = 1'b0;
  logic       out_valid;
  logic       out_ready  = 1'b0;
  logic [7:0] out_byte;
  logic [1:0] out_kind;
  logic       out_end_of_run;

  unescape_checker chk = new();

  int in_idle_pct  = 12;
  int out_idle_pct = 45;
  int items_sent   = 0;

  string simple_chars = "abfnrtv\\?'\"";
  string hex_chars    = "0123456789abcdefABCDEF";
  string bad_chars    = "qzkQ89 e";

  c_escape_sequence_decoder_top u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .in_is_last     (in_is_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_kind       (out_kind),
    .out_end_of_run (out_end_of_run)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Receiver: decide backpressure at the falling edge so it is stable at the rising edge.
  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= out_idle_pct);
  end

  // Check every result transfer against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) chk.check_decoded(out_byte, out_kind, out_end_of_run);
  end

  // Present one source byte, idling at random first; return at the falling edge after the transfer.
  task automatic send_byte(input logic [7:0] c, input logic last);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    in_byte    = c;
    in_is_last = last;
    do @(posedge clk); while (!in_ready);
    chk.note_source_byte(c, last);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_string(input byte_q_t s, input ending_e how);
    foreach (s[i]) send_byte(s[i], (how == END_LAST) && (i == s.size() - 1));
    if (how != END_LAST) send_byte(CH_NUL, how == END_ZERO_LAST);
  endtask

  task automatic send_text(input string t, input ending_e how);
    byte_q_t s;
    for (int i = 0; i < t.len(); i++) s.insert(s.size(), t[i]);
    send_string(s, how);
  endtask

  // Append one well-formed or deliberately broken piece of a string literal.
  function automatic void add_piece(ref byte_q_t s);
    int         pick;
    int         n;
    logic [7:0] c;
    pick = $urandom_range(99);
    if (pick < 35) begin
      c = ($urandom_range(9) == 0) ? 8'($urandom_range(255, 128)) : 8'($urandom_range(126, 32));
      if (c == CH_BSL) c = "A";
      s.insert(s.size(), c);
    end else if (pick < 55) begin
      s.insert(s.size(), CH_BSL);
      s.insert(s.size(), simple_chars[$urandom_range(simple_chars.len() - 1)]);
    end else if (pick < 70) begin
      n = $urandom_range(3, 1);
      s.insert(s.size(), CH_BSL);
      repeat (n) s.insert(s.size(), CH_0 + 8'($urandom_range(7)));
    end else if (pick < 85) begin
      n = $urandom_range(3, 1);
      s.insert(s.size(), CH_BSL);
      s.insert(s.size(), $urandom_range(1) ? "x" : "X");
      repeat (n) s.insert(s.size(), hex_chars[$urandom_range(hex_chars.len() - 1)]);
    end else if (pick < 90) begin
      s.insert(s.size(), CH_BSL);
      s.insert(s.size(), $urandom_range(1) ? "u" : "U");
    end else if (pick < 95) begin
      s.insert(s.size(), CH_BSL);
      s.insert(s.size(), bad_chars[$urandom_range(bad_chars.len() - 1)]);
    end else begin
      // hex escape with no digit
      s.insert(s.size(), CH_BSL);
      s.insert(s.size(), "x");
      s.insert(s.size(), "g");
    end
  endfunction

  task automatic send_random_string();
    byte_q_t s;
    int      pick;
    ending_e how;
    if ($urandom_range(99) < 15) begin
      // raw noise, zero bytes and high bytes included
      repeat ($urandom_range(8, 1)) s.insert(s.size(), 8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(6, 1)) add_piece(s);
      if ($urandom_range(19) == 0) s.insert(s.size(), CH_BSL);
    end
    pick = $urandom_range(99);
    how  = (pick < 60) ? END_LAST : (pick < 85) ? END_ZERO : END_ZERO_LAST;
    send_string(s, how);
  endtask

  // Hold the sender off until every predicted result has drained.
  task automatic drain_results();
    in_valid = 1'b0;
    while (chk.due.size() != 0) @(negedge clk);
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // Directed: high bytes, simple escape, third octal digit, hex at the 0xFF edge,
    // hex overflow closed by a zero byte, octal pending at the end mark,
    // trailing backslash, zero byte with the end mark, unknown escape then dropped text.
    send_byte(8'hff, 1'b0);
    send_text("\\n\\123\\xFFz", END_LAST);
    send_text("\\x100", END_ZERO);
    send_text("\\7", END_LAST);
    send_text("\\", END_LAST);
    send_text("", END_ZERO_LAST);
    send_text("\\qA", END_LAST);

    // Phase 1: sender idles lightly, receiver stalls often.
    while (items_sent < 107) send_random_string();
    drain_results();

    // Phase 2: swap the idle rates.
    in_idle_pct  = 45;
    out_idle_pct = 12;
    while (items_sent < 190) send_random_string();
    drain_results();

    // Phase 3: full rate both sides.
    in_idle_pct  = 0;
    out_idle_pct = 0;
    while (items_sent < 270) send_random_string();
    drain_results();

    // Let any stray result surface before judging.
    repeat (16) @(negedge clk);
    if (chk.mismatches == 0) begin
      $display("tb_c_escape_sequence_decoder_top: clean");
    end else begin
      $display("tb_c_escape_sequence_decoder_top: errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #400000;
    $display("tb_c_escape_sequence_decoder_top: errors");
    $finish;
  end

endmodule
